### hw/rtl/lhgu_pkg.sv
`default_nettype none
package lhgu_pkg;

  // Angles in 1/256 centidegree
  localparam int DEG_UNITS   = 25600;
  localparam int CORDIC_N    = 16;
  localparam int ANG_W       = 28;
  localparam logic [3:0] CELL_CLEAR = 4'd7;
  localparam logic [3:0] CELL_MAX   = 4'd15;

  // Operation codes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // Register indexes
  localparam logic [1:0] REG_CELL_SIZE = 2'd0;
  localparam logic [1:0] REG_MAX_RANGE = 2'd1;
  localparam logic [1:0] REG_HIT_BAND  = 2'd2;
  localparam logic [1:0] REG_BEAM_HALF = 2'd3;

  // Classified update command passed from front to back
  typedef struct packed {
    logic              oob;
    logic signed [7:0]  u;
    logic signed [7:0]  v;
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic signed [15:0] hd;
  } cmd_t;

  // CORDIC arctangent table, rounded
  function automatic logic [20:0] atan_lut(input logic [3:0] i);
    logic [20:0] r;
    begin
      case (i)
        4'd0:  r = 21'd1152000;
        4'd1:  r = 21'd680065;
        4'd2:  r = 21'd359328;
        4'd3:  r = 21'd182400;
        4'd4:  r = 21'd91554;
        4'd5:  r = 21'd45822;
        4'd6:  r = 21'd22916;
        4'd7:  r = 21'd11459;
        4'd8:  r = 21'd5730;
        4'd9:  r = 21'd2865;
        4'd10: r = 21'd1432;
        4'd11: r = 21'd716;
        4'd12: r = 21'd358;
        4'd13: r = 21'd179;
        4'd14: r = 21'd90;
        default: r = 21'd45;
      endcase
      return r;
    end
  endfunction

  // value*100/15 for a 4-bit value
  function automatic logic [6:0] pct_lut(input logic [3:0] val);
    logic [6:0] r;
    begin
      case (val)
        4'd0: r = 7'd0;   4'd1: r = 7'd6;   4'd2: r = 7'd13;  4'd3: r = 7'd20;
        4'd4: r = 7'd26;  4'd5: r = 7'd33;  4'd6: r = 7'd40;  4'd7: r = 7'd46;
        4'd8: r = 7'd53;  4'd9: r = 7'd60;  4'd10: r = 7'd66; 4'd11: r = 7'd73;
        4'd12: r = 7'd80; 4'd13: r = 7'd86; 4'd14: r = 7'd93;
        default: r = 7'd100;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

### hw/rtl/lhgu_ram.sv
`default_nettype none
module lhgu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### hw/rtl/lhgu_cmd_fifo.sv
`default_nettype none
module lhgu_cmd_fifo
  import lhgu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  cmd_t      wdata,
  output logic      full,
  input  wire logic rd,
  output cmd_t      rdata,
  output logic      empty
);
  // two-entry queue between front and back
  cmd_t       slot [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = slot[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) slot[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0; rptr <= 1'b0; count <= 2'd0;
    end else begin
      if (wr && !full) wptr <= ~wptr;
      if (rd && !empty) rptr <= ~rptr;
      case ({wr && !full, rd && !empty})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end
endmodule
`default_nettype wire

### hw/rtl/lhgu_back.sv
`default_nettype none
module lhgu_back
  import lhgu_pkg::*;
#(
  parameter int GRID_SIDE  = 256,
  parameter int BEAM_COUNT = 181
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [9:0]  cell_size_mm,
  input  wire logic [14:0] max_range_mm,
  input  wire logic [10:0] hit_band_mm,
  input  wire logic [6:0]  beam_halfwidth_cdeg,
  // beam store read
  output logic [$clog2(BEAM_COUNT)-1:0] beam_raddr,
  input  wire logic [14:0]              beam_rdata,
  // command queue
  input  cmd_t       cmd,
  input  wire logic  cmd_empty,
  output logic       cmd_pop,
  // results
  output logic        empty,
  input  wire logic   pop,
  output logic [15:0] cell_index,
  output logic [3:0]  cell_value,
  output logic [6:0]  occupancy_percent,
  output logic        updated,
  output logic        busy
);
  localparam int AW   = $clog2(GRID_SIDE * GRID_SIDE);
  localparam int SW   = $clog2(GRID_SIDE);
  localparam int BW   = $clog2(BEAM_COUNT);
  localparam int HALF = (BEAM_COUNT - 1) / 2;
  localparam int DEPTH = GRID_SIDE * GRID_SIDE;
  localparam logic signed [ANG_W-1:0] HALF_TURN = ANG_W'(180 * DEG_UNITS);
  localparam logic signed [ANG_W-1:0] FULL_TURN = ANG_W'(360 * DEG_UNITS);
  localparam logic signed [ANG_W-1:0] HALF_LIM  = ANG_W'(HALF * DEG_UNITS);
  localparam logic signed [ANG_W-1:0] QUARTER   = ANG_W'(90 * DEG_UNITS);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_SQ    = 4'd3;
  localparam logic [3:0] S_CORD  = 4'd4;
  localparam logic [3:0] S_ANG   = 4'd5;
  localparam logic [3:0] S_BEAM  = 4'd6;
  localparam logic [3:0] S_DIFF  = 4'd7;
  localparam logic [3:0] S_RNG   = 4'd8;
  localparam logic [3:0] S_CMP   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state;
  logic [AW:0] clr_cnt;
  cmd_t c;
  logic [AW-1:0] idx;
  logic signed [17:0] pu, pv;
  logic [34:0] dxx, dyy;
  logic [35:0] d2;
  logic [29:0] lim;
  logic        in_range;
  logic signed [40:0] cx, cy;
  logic signed [ANG_W-1:0] cz;
  logic [3:0] it;
  logic signed [ANG_W-1:0] ang;
  logic [BW-1:0] beam;
  logic        in_beam;
  logic [16:0] hi;
  logic [16:0] lo;
  logic        lo_pos;
  logic [33:0] hi2;
  logic [33:0] lo2;
  logic [29:0] z2;
  logic [3:0]  gval;
  logic        res_full;
  logic [3:0]  rval;
  logic        rupd;

  // grid memory
  logic          g_we;
  logic [AW-1:0] g_waddr;
  logic [3:0]    g_wdata;
  logic [3:0]    g_rdata;

  lhgu_ram #(.WIDTH(4), .DEPTH(DEPTH)) u_grid (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .raddr(idx), .rdata(g_rdata)
  );

  assign busy    = (state != S_IDLE) || res_full;
  assign empty   = !res_full;
  assign cmd_pop = (state == S_IDLE) && !cmd_empty && !res_full;
  assign beam_raddr = beam;

  // grid index from cell coordinates
  logic [SW:0] gx, gy;
  assign gx = (SW+1)'(GRID_SIDE / 2) + (SW+1)'(signed'(cmd.u));
  assign gy = (SW+1)'(GRID_SIDE / 2) + (SW+1)'(signed'(cmd.v));

  // offset from robot to cell, up to 19 bits signed
  logic signed [18:0] ex, ey;
  assign ex = 19'(pu) - 19'(c.rx);
  assign ey = 19'(pv) - 19'(c.ry);

  // CORDIC step
  logic signed [40:0] xs, ys;
  assign xs = (cx < 0) ? -((-cx) >>> it) : (cx >>> it);
  assign ys = (cy < 0) ? -((-cy) >>> it) : (cy >>> it);

  // local angle wrap
  logic signed [ANG_W-1:0] araw, awr;
  always_comb begin
    araw = cz - ANG_W'(signed'(c.hd) * 256);
    if (araw > HALF_TURN)        awr = araw - FULL_TURN;
    else if (araw <= -HALF_TURN) awr = araw + FULL_TURN;
    else                         awr = araw;
  end

  // nearest beam: (mag + half degree) / 25600 as >> 10, then / 25 by
  // reciprocal multiply (5243 / 2^17), exact for any in-fan angle
  logic [ANG_W-1:0] mag, mr;
  logic [12:0] mt;
  logic [25:0] mp;
  logic [8:0] nn;
  always_comb begin
    mag = ang[ANG_W-1] ? ANG_W'(-ang) : ANG_W'(ang);
    mr  = mag + ANG_W'(DEG_UNITS / 2);
    mt  = mr[22:10];
    mp  = mt * 13'd5243;
    nn  = mp[25:17];
  end

  // beam difference
  logic signed [ANG_W-1:0] dang, dwr, dabs;
  always_comb begin
    dang = ang - ANG_W'((HALF - int'(beam)) * DEG_UNITS);
    if (dang > HALF_TURN)        dwr = dang - FULL_TURN;
    else if (dang <= -HALF_TURN) dwr = dang + FULL_TURN;
    else                         dwr = dang;
    dabs = dwr[ANG_W-1] ? -dwr : dwr;
  end

  logic hit;
  assign hit = ({d2, 2'b00} < {4'd0, hi2}) &&
               (!lo_pos || ({d2, 2'b00} > {4'd0, lo2}));

  // counter update: +3 on a hit, -1 when nearer than the reading
  always_comb begin
    rupd = 1'b0;
    rval = gval;
    if (in_range && in_beam) begin
      if (hit) begin
        rval = (gval > 4'd12) ? CELL_MAX : gval + 4'd3;
        rupd = 1'b1;
      end else if (d2 < {6'd0, z2}) begin
        rval = (gval == 4'd0) ? 4'd0 : gval - 4'd1;
        rupd = 1'b1;
      end
    end
  end

  // grid write port: clearing sweep, then at most one write-back per update
  always_ff @(posedge clk) begin
    if (rst) begin
      g_we <= 1'b0;
    end else if (state == S_CLEAR) begin
      g_we <= 1'b1; g_waddr <= clr_cnt[AW-1:0]; g_wdata <= CELL_CLEAR;
    end else if (state == S_DONE) begin
      g_we <= rupd; g_waddr <= idx; g_wdata <= rval;
    end else begin
      g_we <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; clr_cnt <= '0; res_full <= 1'b0;
    end else begin
      if (pop && res_full) res_full <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (AW+1)'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: if (cmd_pop) begin
          c   <= cmd;
          idx <= AW'(gx[SW-1:0]) + AW'(AW'(gy[SW-1:0]) * AW'(GRID_SIDE));
          if (cmd.oob) begin
            res_full <= 1'b1; cell_index <= '0; cell_value <= '0;
            occupancy_percent <= '0; updated <= 1'b0;
          end else state <= S_MUL;
        end
        S_MUL: begin
          pu  <= 18'(signed'(c.u) * signed'({1'b0, cell_size_mm}));
          pv  <= 18'(signed'(c.v) * signed'({1'b0, cell_size_mm}));
          lim <= max_range_mm * max_range_mm;
          state <= S_SQ;
        end
        S_SQ: begin
          dxx <= 35'(ex * ex);
          dyy <= 35'(ey * ey);
          state <= S_CORD;
          it <= '0;
          if (ex < 0) begin
            if (ey >= 0) begin
              cx <= 41'(ey) <<< 20; cy <= -(41'(ex) <<< 20);
              cz <= QUARTER;
            end else begin
              cx <= -(41'(ey) <<< 20); cy <= 41'(ex) <<< 20;
              cz <= -QUARTER;
            end
          end else begin
            cx <= 41'(ex) <<< 20; cy <= 41'(ey) <<< 20;
            cz <= '0;
          end
        end
        S_CORD: begin
          if (it == 4'd0) begin
            d2 <= {1'b0, dxx} + {1'b0, dyy};
          end
          if (cy >= 0) begin
            cx <= cx + ys; cy <= cy - xs; cz <= cz + ANG_W'(atan_lut(it));
          end else begin
            cx <= cx - ys; cy <= cy + xs; cz <= cz - ANG_W'(atan_lut(it));
          end
          it <= it + 4'd1;
          if (it == 4'(CORDIC_N - 1)) state <= S_ANG;
        end
        S_ANG: begin
          in_range <= (d2 != '0) && (d2 <= {6'd0, lim});
          ang <= awr;
          state <= S_BEAM;
        end
        S_BEAM: begin
          if (ang > HALF_LIM) beam <= '0;
          else if (ang < -HALF_LIM) beam <= BW'(2 * HALF);
          else if (ang[ANG_W-1]) beam <= BW'(HALF + int'(nn));
          else beam <= BW'(HALF - int'(nn));
          state <= S_DIFF;
        end
        S_DIFF: begin
          // beam read address settles this cycle, data next
          in_beam <= dabs <= ANG_W'(beam_halfwidth_cdeg * 256);
          state <= S_RNG;
        end
        S_RNG: begin
          hi     <= {1'b0, beam_rdata, 1'b0} + 17'(hit_band_mm);
          lo     <= {1'b0, beam_rdata, 1'b0} - 17'(hit_band_mm);
          lo_pos <= {beam_rdata, 1'b0} > 16'(hit_band_mm);
          z2     <= beam_rdata * beam_rdata;
          gval   <= g_rdata;
          state  <= S_CMP;
        end
        S_CMP: begin
          hi2 <= hi * hi;
          lo2 <= 34'(lo[15:0] * lo[15:0]);
          state <= S_DONE;
        end
        S_DONE: begin
          res_full <= 1'b1;
          cell_index <= 16'(idx); cell_value <= rval;
          occupancy_percent <= pct_lut(rval); updated <= rupd;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### hw/rtl/lhgu_front.sv
`default_nettype none
module lhgu_front
  import lhgu_pkg::*;
#(
  parameter int GRID_SIDE  = 256,
  parameter int BEAM_COUNT = 181
) (
  input  wire logic        push,
  output logic             full,
  input  wire logic        operation,
  input  wire logic [7:0]  beam_index,
  input  wire logic [14:0] range_mm,
  input  wire logic signed [7:0]  cell_u,
  input  wire logic signed [7:0]  cell_v,
  input  wire logic signed [15:0] robot_x_mm,
  input  wire logic signed [15:0] robot_y_mm,
  input  wire logic signed [15:0] heading_cdeg,
  input  wire logic        q_full,
  output logic             q_wr,
  output cmd_t             q_data,
  output logic             b_we,
  output logic [$clog2(BEAM_COUNT)-1:0] b_waddr,
  output logic [14:0]      b_wdata,
  input  wire logic        back_busy
);
  localparam int HG = GRID_SIDE / 2;
  localparam int BW = $clog2(BEAM_COUNT);
  logic acc;
  logic signed [11:0] ux, vy;

  // loads must not overtake pending updates that read the beam store
  assign full = q_full || (operation == OP_LOAD && back_busy);
  assign acc = push && !full;

  assign ux = 12'(HG) + 12'(cell_u);
  assign vy = 12'(HG) + 12'(cell_v);

  always_comb begin
    q_data.oob = (ux < 0) || (ux >= 12'(GRID_SIDE)) || (vy < 0) || (vy >= 12'(GRID_SIDE));
    q_data.u = cell_u; q_data.v = cell_v;
    q_data.rx = robot_x_mm; q_data.ry = robot_y_mm; q_data.hd = heading_cdeg;
  end

  assign q_wr    = acc && operation == OP_UPDATE;
  assign b_we    = acc && operation == OP_LOAD && 9'(beam_index) < 9'(BEAM_COUNT);
  assign b_waddr = BW'(beam_index);
  assign b_wdata = range_mm;
endmodule
`default_nettype wire

### hw/rtl/laser_himm_grid_update_top.sv
// Laser occupancy grid update (histogramic in-motion mapping).
// Input channel is a queue: push/full. Load items (operation 0) store one
// beam range; update items (operation 1) name a cell and carry the pose.
// Result channel is a queue: empty/pop; one result per update item, none
// per load. Configuration: cfg_we/cfg_index/cfg_data, written while idle.
// An update's result passes through these steps after its transfer: queue
// pop, operand multiply, squares, a 16-iteration CORDIC atan2, beam pick,
// beam-store read, band squares and the grid read-modify-write. An
// out-of-grid cell skips them: its result is registered at the queue pop.
// One update is worked at a time, and the next starts only once the result
// is popped. A two-entry queue lets the front accept further updates
// meanwhile. A load is taken only when no update is pending or waiting,
// so loads and updates keep their order. After reset the grid is swept to
// 7, one cell per cycle (GRID_SIDE^2 cells, 65536 at the default); updates
// queue but start after the sweep. A result waits on the output register
// while pop is low; the back end then holds and the queue fills, raising
// full.
`default_nettype none
module laser_himm_grid_update_top
  import lhgu_pkg::*;
#(
  parameter int GRID_SIDE  = 256,
  parameter int BEAM_COUNT = 181
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        operation,
  input  wire logic [7:0]  beam_index,
  input  wire logic [14:0] range_mm,
  input  wire logic signed [7:0]  cell_u,
  input  wire logic signed [7:0]  cell_v,
  input  wire logic signed [15:0] robot_x_mm,
  input  wire logic signed [15:0] robot_y_mm,
  input  wire logic signed [15:0] heading_cdeg,
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      cell_index,
  output logic [3:0]       cell_value,
  output logic [6:0]       occupancy_percent,
  output logic             updated,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [14:0] cfg_data
);
  localparam int BW = $clog2(BEAM_COUNT);

  logic [9:0]  cell_size_mm;
  logic [14:0] max_range_mm;
  logic [10:0] hit_band_mm;
  logic [6:0]  beam_halfwidth_cdeg;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size_mm <= 10'd100; max_range_mm <= 15'd10000;
      hit_band_mm <= 11'd200; beam_halfwidth_cdeg <= 7'd50;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CELL_SIZE: cell_size_mm        <= cfg_data[9:0];
        REG_MAX_RANGE: max_range_mm        <= cfg_data;
        REG_HIT_BAND:  hit_band_mm         <= cfg_data[10:0];
        REG_BEAM_HALF: beam_halfwidth_cdeg <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  logic    q_wr, q_full, q_empty, q_pop, back_busy, f_full;
  cmd_t    q_wdata, q_rdata;
  logic    b_we;
  logic [BW-1:0] b_waddr, b_raddr;
  logic [14:0]   b_wdata, b_rdata;

  assign full = f_full || (operation == OP_LOAD && !q_empty);

  lhgu_front #(.GRID_SIDE(GRID_SIDE), .BEAM_COUNT(BEAM_COUNT)) u_front (
    .push(push && !(operation == OP_LOAD && !q_empty)),
    .full(f_full), .operation(operation), .beam_index(beam_index),
    .range_mm(range_mm), .cell_u(cell_u), .cell_v(cell_v),
    .robot_x_mm(robot_x_mm), .robot_y_mm(robot_y_mm), .heading_cdeg(heading_cdeg),
    .q_full(q_full), .q_wr(q_wr), .q_data(q_wdata),
    .b_we(b_we), .b_waddr(b_waddr), .b_wdata(b_wdata), .back_busy(back_busy)
  );

  lhgu_ram #(.WIDTH(15), .DEPTH(BEAM_COUNT)) u_beams (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  lhgu_cmd_fifo u_fifo (
    .clk(clk), .rst(rst), .wr(q_wr), .wdata(q_wdata), .full(q_full),
    .rd(q_pop), .rdata(q_rdata), .empty(q_empty)
  );

  lhgu_back #(.GRID_SIDE(GRID_SIDE), .BEAM_COUNT(BEAM_COUNT)) u_back (
    .clk(clk), .rst(rst),
    .cell_size_mm(cell_size_mm), .max_range_mm(max_range_mm),
    .hit_band_mm(hit_band_mm), .beam_halfwidth_cdeg(beam_halfwidth_cdeg),
    .beam_raddr(b_raddr), .beam_rdata(b_rdata),
    .cmd(q_rdata), .cmd_empty(q_empty), .cmd_pop(q_pop),
    .empty(empty), .pop(pop), .cell_index(cell_index), .cell_value(cell_value),
    .occupancy_percent(occupancy_percent), .updated(updated), .busy(back_busy)
  );
endmodule
`default_nettype wire
